// ===== rtl/mdbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message-delimited byte FIFO package
// Shared constants, codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mdbf_pkg;

  localparam int unsigned DefDepth   = 256;
  localparam int unsigned DefMaxRead = 64;

  // Request kinds on the slave side.
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Outcome codes on the master side.
  localparam logic [1:0] OUTCOME_OK    = 2'd0;
  localparam logic [1:0] OUTCOME_EMPTY = 2'd1;
  localparam logic [1:0] OUTCOME_FULL  = 2'd2;

  typedef struct packed {
    logic take_push;
    logic take_status;
    logic take_read_empty;
    logic read_start;
    logic scan_prime;
    logic scan_next;
    logic scan_stop;
    logic emit_load;
  } mdbf_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic scan_hit;
    logic emit_last;
    logic out_free;
  } mdbf_status_t;

endpackage

// ===== rtl/mdbf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module mdbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mdbf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message-delimited byte FIFO controller
// Sequences push, status and read requests; a read first scans the stored
// bytes to find the message length, then re-reads and emits them.
// ----------------------------------------------------------------------------
module mdbf_ctrl
  import mdbf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [1:0]   in_kind_i,
  output logic         in_ready_o,
  input  mdbf_status_t status_i,
  output mdbf_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_WAIT,
    ST_SCAN,
    ST_EMIT_WAIT,
    ST_EMIT_LOAD,
    ST_EMIT_GAP
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (in_kind_i)
            KIND_PUSH: cmd_o.take_push = 1'b1;
            KIND_READ: begin
              if (status_i.occ_zero) begin
                cmd_o.take_read_empty = 1'b1;
              end else begin
                cmd_o.read_start = 1'b1;
                state_d          = ST_SCAN_WAIT;
              end
            end
            default: cmd_o.take_status = 1'b1;
          endcase
        end
      end
      ST_SCAN_WAIT: begin
        cmd_o.scan_prime = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_hit) begin
          cmd_o.scan_stop = 1'b1;
          state_d         = ST_EMIT_WAIT;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_EMIT_WAIT: begin
        state_d = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = status_i.emit_last ? ST_IDLE : ST_EMIT_GAP;
        end
      end
      ST_EMIT_GAP: begin
        // The registered RAM read has not yet presented the byte at the new pointer.
        state_d = ST_EMIT_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/mdbf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message-delimited byte FIFO datapath
// Holds the ring pointers, fill level, call counters, the byte store and the
// output register.
// ----------------------------------------------------------------------------
module mdbf_dp
  import mdbf_pkg::*;
#(
  parameter int unsigned Depth   = DefDepth,
  parameter int unsigned MaxRead = DefMaxRead
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   push_byte_i,
  input  logic         burst_end_i,
  input  logic [6:0]   read_limit_i,
  input  mdbf_cmd_t    cmd_i,
  output mdbf_status_t status_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [7:0]   read_byte_o,
  output logic [1:0]   outcome_o,
  output logic         last_o,
  output logic [8:0]   fill_level_o,
  output logic [31:0]  reads_done_o,
  output logic [31:0]  writes_done_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned OW = $clog2(Depth + 1);
  localparam int unsigned CW = $clog2(MaxRead + 1);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [31:0]   reads_q, reads_d, writes_q, writes_d;
  logic [CW-1:0] cnt_q, cnt_d, lim_q, lim_d, nm1_q, nm1_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    byte_q, byte_d;
  logic [1:0]    outcome_q, outcome_d;
  logic          last_q, last_d;
  logic [8:0]    fill_q, fill_d;
  logic [31:0]   rdn_q, rdn_d, wrn_q, wrn_d;

  logic [7:0]    rdata;
  logic          full;
  logic          ram_we;
  logic [AW-1:0] tail_inc, rd_ptr_inc;
  logic [31:0]   head_sum, head_wrap, lim_raw, cnt_next;

  assign full       = (occ_q == OW'(Depth));
  assign ram_we     = cmd_i.take_push && !full;
  assign tail_inc   = (tail_q == AW'(Depth - 1)) ? '0 : tail_q + AW'(1);
  assign rd_ptr_inc = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
  assign cnt_next   = 32'(cnt_q) + 32'd1;
  assign head_sum   = 32'(head_q) + cnt_next;
  assign head_wrap  = (head_sum >= Depth) ? head_sum - Depth : head_sum;

  always_comb begin
    if (read_limit_i == 7'd0) begin
      lim_raw = 32'd1;
    end else if (32'(read_limit_i) > MaxRead) begin
      lim_raw = MaxRead;
    end else begin
      lim_raw = 32'(read_limit_i);
    end
  end

  mdbf_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(push_byte_i),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  // A message ends at a NUL byte, at the read limit, or when the FIFO runs dry.
  assign status_o.occ_zero  = (occ_q == '0);
  assign status_o.scan_hit  = (rdata == 8'h00) || (cnt_next == 32'(lim_q)) ||
                              (cnt_next == 32'(occ_q));
  assign status_o.emit_last = (cnt_q == nm1_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    reads_d     = reads_q;
    writes_d    = writes_q;
    rd_ptr_d    = rd_ptr_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    nm1_d       = nm1_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    outcome_d   = outcome_q;
    last_d      = last_q;
    fill_d      = fill_q;
    rdn_d       = rdn_q;
    wrn_d       = wrn_q;

    if (cmd_i.take_push) begin
      if (!full) begin
        tail_d = tail_inc;
        occ_d  = occ_q + OW'(1);
      end
      if (burst_end_i) begin
        writes_d = writes_q + 32'd1;
      end
      out_valid_d = 1'b1;
      byte_d      = 8'h00;
      outcome_d   = full ? OUTCOME_FULL : OUTCOME_OK;
      last_d      = 1'b1;
      fill_d      = 9'(occ_d);
      rdn_d       = reads_q;
      wrn_d       = writes_d;
    end

    if (cmd_i.take_status || cmd_i.take_read_empty) begin
      out_valid_d = 1'b1;
      byte_d      = 8'h00;
      outcome_d   = cmd_i.take_read_empty ? OUTCOME_EMPTY : OUTCOME_OK;
      last_d      = 1'b1;
      fill_d      = 9'(occ_q);
      rdn_d       = reads_q;
      wrn_d       = writes_q;
    end

    if (cmd_i.read_start) begin
      rd_ptr_d = head_q;
      cnt_d    = '0;
      lim_d    = CW'(lim_raw);
    end

    if (cmd_i.scan_prime) begin
      rd_ptr_d = rd_ptr_inc;
    end

    if (cmd_i.scan_next) begin
      rd_ptr_d = rd_ptr_inc;
      cnt_d    = cnt_q + CW'(1);
    end

    // The length is known now, so the FIFO state is committed before the
    // bytes go out and every result carries the final level and count.
    if (cmd_i.scan_stop) begin
      nm1_d    = cnt_q;
      head_d   = AW'(head_wrap);
      occ_d    = occ_q - OW'(cnt_next);
      reads_d  = reads_q + 32'd1;
      rd_ptr_d = head_q;
      cnt_d    = '0;
    end

    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
      byte_d      = rdata;
      outcome_d   = OUTCOME_OK;
      last_d      = (cnt_q == nm1_q);
      fill_d      = 9'(occ_q);
      rdn_d       = reads_q;
      wrn_d       = writes_q;
      rd_ptr_d    = rd_ptr_inc;
      cnt_d       = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      reads_q     <= '0;
      writes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      reads_q     <= reads_d;
      writes_q    <= writes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    cnt_q     <= cnt_d;
    lim_q     <= lim_d;
    nm1_q     <= nm1_d;
    byte_q    <= byte_d;
    outcome_q <= outcome_d;
    last_q    <= last_d;
    fill_q    <= fill_d;
    rdn_q     <= rdn_d;
    wrn_q     <= wrn_d;
  end

  assign out_valid_o   = out_valid_q;
  assign read_byte_o   = byte_q;
  assign outcome_o     = outcome_q;
  assign last_o        = last_q;
  assign fill_level_o  = fill_q;
  assign reads_done_o  = rdn_q;
  assign writes_done_o = wrn_q;

endmodule

// ===== rtl/message_delimited_byte_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message-delimited byte FIFO
// Circular byte FIFO with non-blocking push, NUL-delimited message read and
// a status query.
//
//   Channel   Direction  Data                                  Side bands
//   s_axis    in         push_byte, read_limit                 tuser kind, tlast burst_end
//   m_axis    out        read_byte, fill_level, reads, writes  tuser outcome, tlast last
//
// A push or status request gives one result.
// A read returning n bytes uses the single RAM read port first to scan the
// message for its length, then to re-read and emit the bytes, with a gap
// state after every byte but the last while the RAM read catches up.
// Reset clears the head and tail pointers, the fill level and both counters; the byte store
// is not cleared. A stalled master side holds results in the output register
// and stops the controller; no request is accepted while a read is in flight.
// ----------------------------------------------------------------------------
module message_delimited_byte_fifo_top
  import mdbf_pkg::*;
#(
  parameter int unsigned Depth   = DefDepth,
  parameter int unsigned MaxRead = DefMaxRead
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] push_byte, [14:8] read_limit, [15] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  input  logic        s_axis_tlast,  // burst_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // [7:0] read_byte, [16:8] fill_level,
                                     // [48:17] reads_done, [80:49] writes_done, [87:81] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] outcome
  output logic        m_axis_tlast   // last
);

  mdbf_cmd_t    cmd;
  mdbf_status_t status;
  logic [7:0]   read_byte;
  logic [8:0]   fill_level;
  logic [31:0]  reads_done;
  logic [31:0]  writes_done;

  mdbf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_kind_i (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mdbf_dp #(
    .Depth  (Depth),
    .MaxRead(MaxRead)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_byte_i  (s_axis_tdata[7:0]),
    .burst_end_i  (s_axis_tlast),
    .read_limit_i (s_axis_tdata[14:8]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .read_byte_o  (read_byte),
    .outcome_o    (m_axis_tuser),
    .last_o       (m_axis_tlast),
    .fill_level_o (fill_level),
    .reads_done_o (reads_done),
    .writes_done_o(writes_done)
  );

  assign m_axis_tdata = {7'b0, writes_done, reads_done, fill_level, read_byte};

endmodule

// ===== test/message_delimited_byte_fifo_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message-delimited byte FIFO testbench
// Sends push, read and status requests and keeps a mirror of the FIFO. The
// mirror predicts every result of each accepted request. Each result on the
// master side is checked against the oldest prediction. The run goes through
// phases with idle cycles and stalls on the slave and master sides.
// ----------------------------------------------------------------------------
module message_delimited_byte_fifo_top_tb;
  import mdbf_pkg::*;

  localparam int unsigned FifoDepth   = DefDepth;
  localparam int unsigned ReadCap     = DefMaxRead;
  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned PhaseItems  = 40;

  // Kind 3 is not defined by the block and must behave as a status query.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [7:0]  read_byte;
    logic [1:0]  outcome;
    logic        last;
    logic [8:0]  fill_level;
    logic [31:0] reads_done;
    logic [31:0] writes_done;
  } fifo_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] push_byte, [14:8] read_limit, [15] zero
  logic [1:0]  s_axis_tuser = '0;  // [1:0] kind
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // [7:0] read_byte, [16:8] fill_level,
                                   // [48:17] reads_done, [80:49] writes_done
  logic [1:0]  m_axis_tuser;       // [1:0] outcome
  logic        m_axis_tlast;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Mirror of the FIFO contents and counters.
  logic [7:0]   mirror_store [FifoDepth];
  int unsigned  mirror_head   = 0;
  int unsigned  mirror_tail   = 0;
  logic [8:0]   mirror_fill   = '0;
  logic [31:0]  mirror_reads  = '0;
  logic [31:0]  mirror_writes = '0;
  fifo_result_t awaited_results [$];

  message_delimited_byte_fifo_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Applies one accepted request to the mirror and queues its results.
  function automatic void mirror_fifo_step(input logic [1:0] kind, input logic [7:0] data_byte,
                                           input logic burst, input logic [6:0] limit);
    fifo_result_t batch [$];
    fifo_result_t res;
    int unsigned  cap;
    res = '{read_byte: '0, outcome: OUTCOME_OK, last: 1'b0, fill_level: '0,
            reads_done: '0, writes_done: '0};
    if (kind == KIND_PUSH) begin
      if (mirror_fill >= FifoDepth) begin
        res.outcome = OUTCOME_FULL;
      end else begin
        mirror_store[mirror_tail] = data_byte;
        mirror_tail = (mirror_tail + 1) % FifoDepth;
        mirror_fill = mirror_fill + 1;
      end
      if (burst) mirror_writes = mirror_writes + 1;
      batch.push_back(res);
    end else if (kind == KIND_READ && mirror_fill == 0) begin
      res.outcome = OUTCOME_EMPTY;
      batch.push_back(res);
    end else if (kind == KIND_READ) begin
      cap = (limit == 0) ? 1 : ((limit > ReadCap) ? ReadCap : limit);
      while (batch.size() < cap && mirror_fill > 0) begin
        res.read_byte = mirror_store[mirror_head];
        batch.push_back(res);
        mirror_head = (mirror_head + 1) % FifoDepth;
        mirror_fill = mirror_fill - 1;
        if (res.read_byte == 8'h00) break;
      end
      mirror_reads = mirror_reads + 1;
    end else begin
      batch.push_back(res);
    end
    // Every result carries the state as it stands once the whole request is done.
    foreach (batch[k]) begin
      batch[k].last        = (k == batch.size() - 1);
      batch[k].fill_level  = mirror_fill;
      batch[k].reads_done  = mirror_reads;
      batch[k].writes_done = mirror_writes;
      awaited_results.push_back(batch[k]);
    end
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [7:0] data_byte,
                              input logic burst, input logic [6:0] limit);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, limit, data_byte};
    s_axis_tuser  = kind;
    s_axis_tlast  = burst;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    mirror_fifo_step(kind, data_byte, burst, limit);
  endtask

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    fifo_result_t want;
    fifo_result_t got;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got.read_byte   = m_axis_tdata[7:0];
      got.fill_level  = m_axis_tdata[16:8];
      got.reads_done  = m_axis_tdata[48:17];
      got.writes_done = m_axis_tdata[80:49];
      got.outcome     = m_axis_tuser;
      got.last        = m_axis_tlast;
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result byte=%02h outcome=%0d last=%0b",
                                got.read_byte, got.outcome, got.last));
      end else begin
        want = awaited_results.pop_front();
        if (got.read_byte !== want.read_byte || got.outcome !== want.outcome ||
            got.last !== want.last || got.fill_level !== want.fill_level ||
            got.reads_done !== want.reads_done || got.writes_done !== want.writes_done) begin
          note_mismatch({
            $sformatf("expected byte=%02h outcome=%0d last=%0b fill=%0d reads=%0d writes=%0d",
                      want.read_byte, want.outcome, want.last, want.fill_level,
                      want.reads_done, want.writes_done),
            $sformatf(", got byte=%02h outcome=%0d last=%0b fill=%0d reads=%0d writes=%0d",
                      got.read_byte, got.outcome, got.last, got.fill_level,
                      got.reads_done, got.writes_done)});
        end
      end
    end
  end

  task automatic test_directed();
    send_request(KIND_STATUS, 8'h00, 1'b0, 7'd0);
    send_request(KIND_SPARE, 8'hFF, 1'b1, 7'h7F);
    // A read on the empty FIFO, with the fields it ignores set.
    send_request(KIND_READ, 8'hFF, 1'b1, 7'd1);
    send_request(KIND_PUSH, 8'hFF, 1'b0, 7'h7F);
    send_request(KIND_PUSH, 8'h00, 1'b1, 7'd0);
    send_request(KIND_PUSH, 8'hA5, 1'b1, 7'd0);
    // Stops right after the NUL byte.
    send_request(KIND_READ, 8'h00, 1'b0, 7'd64);
    // A limit of zero takes one byte.
    send_request(KIND_READ, 8'h00, 1'b0, 7'd0);
    send_request(KIND_READ, 8'h00, 1'b0, 7'd5);
    send_request(KIND_PUSH, 8'h01, 1'b0, 7'd0);
    send_request(KIND_PUSH, 8'h80, 1'b0, 7'd0);
    send_request(KIND_PUSH, 8'h7E, 1'b1, 7'd0);
    // Limit above the cap; the FIFO empties first.
    send_request(KIND_READ, 8'h00, 1'b0, 7'h7F);
    send_request(KIND_PUSH, 8'h11, 1'b0, 7'd3);
    send_request(KIND_PUSH, 8'h22, 1'b0, 7'd0);
    send_request(KIND_PUSH, 8'h33, 1'b0, 7'd0);
    send_request(KIND_PUSH, 8'h44, 1'b1, 7'd0);
    send_request(KIND_READ, 8'h00, 1'b0, 7'd2);
    send_request(KIND_READ, 8'h00, 1'b0, 7'd65);
    send_request(KIND_STATUS, 8'hFF, 1'b1, 7'h7F);
  endtask

  // Fills the FIFO past full, so that pushes are dropped, then drains it.
  task automatic test_fill_and_drain();
    logic [7:0] b;
    for (int i = 0; i < FifoDepth + 4; i++) begin
      b = ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      send_request(KIND_PUSH, b, (i % 8 == 7) || (i >= FifoDepth), 7'($urandom));
    end
    send_request(KIND_STATUS, 8'($urandom), 1'($urandom), 7'($urandom));
    while (mirror_fill > 0) begin
      send_request(KIND_READ, 8'($urandom), 1'($urandom), 7'($urandom_range(1, 127)));
    end
  endtask

  // Mostly NUL-terminated messages and reads of them, with some noise.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 45 && mirror_fill < FifoDepth - 24) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          b = (i == len - 1) ? 8'h00 : 8'($urandom_range(1, 255));
          send_request(KIND_PUSH, b, i == len - 1, 7'($urandom));
        end
        sent += len;
      end else if (pick < 80) begin
        send_request(KIND_READ, 8'($urandom), 1'($urandom), 7'($urandom));
        sent++;
      end else if (pick < 88) begin
        send_request(($urandom_range(1) == 0) ? KIND_STATUS : KIND_SPARE, 8'($urandom),
                     1'($urandom), 7'($urandom));
        sent++;
      end else begin
        send_request(2'($urandom), 8'($urandom), 1'($urandom), 7'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_directed();
    test_random_traffic(PhaseItems);

    send_idle_pct  = 69;
    recv_stall_pct = 0;
    test_random_traffic(PhaseItems);

    send_idle_pct  = 0;
    recv_stall_pct = 69;
    test_fill_and_drain();
    test_random_traffic(PhaseItems);

    send_idle_pct  = 33;
    recv_stall_pct = 33;
    test_random_traffic(PhaseItems);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
